// ===== hdl/keypad_code_lock_controller_top_defines.svh =====
// Assertion macros shared by the keypad code lock RTL.
// Included by the modules that carry concurrent assertions; needs clk and rst in scope.
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_TOP_DEFINES_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define KCLC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define KCLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/kclc_pkg.sv =====
// Shared types, codes and reset constants of the keypad code lock controller.
// Used by kclc_cfg, kclc_core and the top level; depends on nothing.
package kclc_pkg;

  // Default number of digits in a code.
  localparam int CODE_DIGITS_DEF = 4;

  // Field widths fixed by the interface.
  localparam int KIND_W  = 2;
  localparam int DIGIT_W = 4;
  localparam int DIST_W  = 10;
  localparam int EV_W    = 4;
  localparam int SHOWN_W = 3;
  localparam int ROOT_W  = 16;
  localparam int CFG_IDX_W = 1;

  // Input kinds.
  localparam logic [KIND_W-1:0] KIND_WAKE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DIGIT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DIST  = 2'd2;

  // Result event codes.
  localparam logic [EV_W-1:0] EV_IGNORED = 4'd0;
  localparam logic [EV_W-1:0] EV_DIGIT   = 4'd1;
  localparam logic [EV_W-1:0] EV_GRANTED = 4'd2;
  localparam logic [EV_W-1:0] EV_DENIED  = 4'd3;
  localparam logic [EV_W-1:0] EV_ROOT    = 4'd4;
  localparam logic [EV_W-1:0] EV_CHANGED = 4'd5;
  localparam logic [EV_W-1:0] EV_HELD    = 4'd6;
  localparam logic [EV_W-1:0] EV_ON_HOLD = 4'd7;
  localparam logic [EV_W-1:0] EV_CLOSING = 4'd8;

  // Menu keys.
  localparam logic [DIGIT_W-1:0] KEY_NEW_CODE  = 4'd1;
  localparam logic [DIGIT_W-1:0] KEY_HOLD_OPEN = 4'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_CODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_LIMIT = 1'b1;

  // Reset values.
  localparam logic [ROOT_W-1:0] ROOT_CODE_RST   = 16'h2580;
  localparam logic [DIST_W-1:0] CLEAR_LIMIT_RST = 10'd20;
  localparam logic [ROOT_W-1:0] USER_CODE_RST   = 16'h1234;

  // Controller modes.
  typedef enum logic [2:0] {
    MODE_STANDBY    = 3'd0,
    MODE_ENTRY      = 3'd1,
    MODE_WAIT_CLEAR = 3'd2,
    MODE_ROOT_MENU  = 3'd3,
    MODE_NEW_KEY    = 3'd4,
    MODE_HOLD_OPEN  = 3'd5
  } mode_t;

  // One input item.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [DIGIT_W-1:0] digit;
    logic [DIST_W-1:0]  distance_cm;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [SHOWN_W-1:0] digits_entered;
    logic               lock_open;
    logic [EV_W-1:0]    event_res;
  } result_t;

  // Configuration register contents.
  typedef struct packed {
    logic [ROOT_W-1:0] root_code;
    logic [DIST_W-1:0] clear_limit_cm;
  } cfg_t;

endpackage

// ===== hdl/kclc_cfg.sv =====
// Configuration registers of the keypad code lock: root code and clearance limit.
// Depends on kclc_pkg.
module kclc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [kclc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kclc_pkg::ROOT_W-1:0]      cfg_wdata,
  output kclc_pkg::cfg_t                   cfg
);

  // Register file: one write per cycle, no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.root_code      <= kclc_pkg::ROOT_CODE_RST;
      cfg.clear_limit_cm <= kclc_pkg::CLEAR_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kclc_pkg::CFG_ROOT_CODE: begin
          cfg.root_code <= cfg_wdata;
        end
        kclc_pkg::CFG_CLEAR_LIMIT: begin
          cfg.clear_limit_cm <= cfg_wdata[kclc_pkg::DIST_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/kclc_core.sv =====
// Lock state machine: code entry, comparison, root menu and clearance wait.
// Depends on kclc_pkg and keypad_code_lock_controller_top_defines.svh.
`include "keypad_code_lock_controller_top_defines.svh"

module kclc_core #(
  parameter int CODE_DIGITS = kclc_pkg::CODE_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  kclc_pkg::item_t   item,
  input  kclc_pkg::cfg_t    cfg,
  output kclc_pkg::result_t result
);

  localparam int CW    = 4 * CODE_DIGITS;
  localparam int CNT_W = $clog2(CODE_DIGITS + 1);
  localparam logic [CW+15:0] USER_RST_WIDE = {{CW{1'b0}}, kclc_pkg::USER_CODE_RST};

  kclc_pkg::mode_t  mode, mode_next;
  logic [CNT_W-1:0] digit_count, digit_count_next;
  logic [CW-1:0]    entered_code, entered_code_next;
  logic [CW-1:0]    user_code, user_code_next;
  logic             door_open, door_open_next;

  logic [CNT_W:0]   count_inc;
  logic             entry_done;
  logic [CW+3:0]    shift_wide;
  logic [CW-1:0]    code_shifted;
  logic [CW+15:0]   root_wide;
  logic [CW-1:0]    root_cmp;
  logic             collecting;
  logic             shifting;

  // Shared datapath: digit shift, count increment and the root code at code width.
  assign count_inc    = {1'b0, digit_count} + (CNT_W + 1)'(1);
  assign entry_done   = count_inc >= (CNT_W + 1)'(CODE_DIGITS);
  assign shift_wide   = {entered_code, item.digit};
  assign code_shifted = shift_wide[CW-1:0];
  assign root_wide    = {{CW{1'b0}}, cfg.root_code};
  assign root_cmp     = root_wide[CW-1:0];
  assign collecting   = (mode == kclc_pkg::MODE_ENTRY) || (mode == kclc_pkg::MODE_NEW_KEY);
  assign shifting     = (item.kind == kclc_pkg::KIND_DIGIT) && collecting;

  // Next state.
  always_comb begin
    mode_next         = mode;
    digit_count_next  = digit_count;
    entered_code_next = entered_code;
    user_code_next    = user_code;
    door_open_next    = door_open;
    unique case (item.kind)
      kclc_pkg::KIND_WAKE: begin
        if (mode == kclc_pkg::MODE_STANDBY) begin
          mode_next         = kclc_pkg::MODE_ENTRY;
          digit_count_next  = '0;
          entered_code_next = '0;
        end
      end
      kclc_pkg::KIND_DIGIT: begin
        unique case (mode)
          kclc_pkg::MODE_ENTRY, kclc_pkg::MODE_NEW_KEY: begin
            if (entry_done) begin
              mode_next         = kclc_pkg::MODE_STANDBY;
              digit_count_next  = '0;
              entered_code_next = '0;
              if (mode == kclc_pkg::MODE_NEW_KEY) begin
                user_code_next = code_shifted;
              end else if (code_shifted == user_code) begin
                mode_next      = kclc_pkg::MODE_WAIT_CLEAR;
                door_open_next = 1'b1;
              end else if (code_shifted == root_cmp) begin
                mode_next = kclc_pkg::MODE_ROOT_MENU;
              end
            end else begin
              digit_count_next  = count_inc[CNT_W-1:0];
              entered_code_next = code_shifted;
            end
          end
          kclc_pkg::MODE_ROOT_MENU: begin
            if (item.digit == kclc_pkg::KEY_NEW_CODE) begin
              mode_next         = kclc_pkg::MODE_NEW_KEY;
              digit_count_next  = '0;
              entered_code_next = '0;
            end else if (item.digit == kclc_pkg::KEY_HOLD_OPEN) begin
              mode_next      = kclc_pkg::MODE_HOLD_OPEN;
              door_open_next = 1'b1;
            end
          end
          kclc_pkg::MODE_HOLD_OPEN: begin
            mode_next = kclc_pkg::MODE_WAIT_CLEAR;
          end
          default: begin
          end
        endcase
      end
      kclc_pkg::KIND_DIST: begin
        if ((mode == kclc_pkg::MODE_WAIT_CLEAR) &&
            (item.distance_cm > cfg.clear_limit_cm)) begin
          mode_next         = kclc_pkg::MODE_STANDBY;
          digit_count_next  = '0;
          entered_code_next = '0;
          door_open_next    = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Result for the current item.
  always_comb begin
    result.event_res = kclc_pkg::EV_IGNORED;
    unique case (item.kind)
      kclc_pkg::KIND_DIGIT: begin
        unique case (mode)
          kclc_pkg::MODE_ENTRY: begin
            if (!entry_done) begin
              result.event_res = kclc_pkg::EV_DIGIT;
            end else if (code_shifted == user_code) begin
              result.event_res = kclc_pkg::EV_GRANTED;
            end else if (code_shifted == root_cmp) begin
              result.event_res = kclc_pkg::EV_ROOT;
            end else begin
              result.event_res = kclc_pkg::EV_DENIED;
            end
          end
          kclc_pkg::MODE_NEW_KEY: begin
            result.event_res = entry_done ? kclc_pkg::EV_CHANGED : kclc_pkg::EV_DIGIT;
          end
          kclc_pkg::MODE_ROOT_MENU: begin
            if (item.digit == kclc_pkg::KEY_NEW_CODE) begin
              result.event_res = kclc_pkg::EV_DIGIT;
            end else if (item.digit == kclc_pkg::KEY_HOLD_OPEN) begin
              result.event_res = kclc_pkg::EV_HELD;
            end
          end
          kclc_pkg::MODE_HOLD_OPEN: begin
            result.event_res = kclc_pkg::EV_ON_HOLD;
          end
          default: begin
          end
        endcase
      end
      kclc_pkg::KIND_DIST: begin
        if (mode == kclc_pkg::MODE_WAIT_CLEAR) begin
          result.event_res = (item.distance_cm > cfg.clear_limit_cm) ?
                             kclc_pkg::EV_CLOSING : kclc_pkg::EV_ON_HOLD;
        end
      end
      default: begin
      end
    endcase
    result.lock_open = door_open_next;
    // A digit that completes an entry still shows the full count.
    if (shifting) begin
      result.digits_entered = kclc_pkg::SHOWN_W'(count_inc);
    end else if (collecting) begin
      result.digits_entered = kclc_pkg::SHOWN_W'(digit_count);
    end else begin
      result.digits_entered = '0;
    end
  end

  // State registers, updated once per processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= kclc_pkg::MODE_STANDBY;
      digit_count  <= '0;
      entered_code <= '0;
      user_code    <= USER_RST_WIDE[CW-1:0];
      door_open    <= 1'b0;
    end else if (fire) begin
      mode         <= mode_next;
      digit_count  <= digit_count_next;
      entered_code <= entered_code_next;
      user_code    <= user_code_next;
      door_open    <= door_open_next;
    end
  end

  `KCLC_ASSERT_NOW(a_door_tracks_mode, 1'b1, door_open == ((mode == kclc_pkg::MODE_WAIT_CLEAR) || (mode == kclc_pkg::MODE_HOLD_OPEN)), "door state disagrees with mode")
  `KCLC_ASSERT_NOW(a_count_bounded, 1'b1, ({1'b0, digit_count} < (CNT_W + 1)'(CODE_DIGITS)) && (collecting || (digit_count == '0)), "digit count out of range")
  `KCLC_ASSERT_NEXT(a_user_code_kept, !(fire && (result.event_res == kclc_pkg::EV_CHANGED)), $stable(user_code), "user code changed without a key change")

endmodule

// ===== hdl/keypad_code_lock_controller_top.sv =====
// Top level of the keypad code lock controller: input and result registers.
// Depends on kclc_pkg, kclc_cfg and kclc_core.
//
// Use of the block:
//   Slave channel s_*: one event per transfer; s_tuser is the event kind
//   (wake press, keypad digit, distance sample), s_tdata carries the key
//   and the measured distance. Master channel m_*: exactly one result per
//   event, holding the event code, the latch state and the digit count.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index
//   (0 root code, 1 clearance limit); the user must write only while idle,
//   the block does not enforce it. An event passes the input register,
//   then the result register, before m_tvalid rises.
//   Throughput: one event per cycle while m_tready is high; the state machine
//   update is a single compare-and-select pass between the input and result register.
//   Reset (rst, synchronous) clears both stages, puts the lock in standby,
//   locked, with the default user and root codes.
//   When the receiver holds m_tready low the result stays in place; the
//   input register still takes one more event, then s_tready falls until
//   the result is taken.
module keypad_code_lock_controller_top #(
  parameter int CODE_DIGITS = kclc_pkg::CODE_DIGITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,   // [3:0] digit, [13:4] distance_cm
  input  logic [kclc_pkg::KIND_W-1:0]    s_tuser,   // [1:0] kind
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [3:0] event_res, [4] lock_open,
                                                    // [7:5] digits_entered
  input  logic                           cfg_we,
  input  logic [kclc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kclc_pkg::ROOT_W-1:0]    cfg_wdata
);

  kclc_pkg::item_t   item_q;
  logic              in_valid;
  kclc_pkg::result_t result_comb;
  kclc_pkg::result_t result_q;
  logic              out_valid;
  logic              advance;
  kclc_pkg::cfg_t    cfg;

  // The input stage moves on when the result register is free or being emptied.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_q.kind        <= s_tuser;
      item_q.digit       <= s_tdata[3:0];
      item_q.distance_cm <= s_tdata[13:4];
    end
  end

  kclc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kclc_core #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (item_q),
    .cfg    (cfg),
    .result (result_comb)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result_comb;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = result_q;

endmodule
